// File: design/bq_pkg.sv
// ----------------------------------------------------------------------------
// Biquad filter package
// Shared widths, fixed-point constants, register indexes and types for the
// transposed direct form II biquad section.
// ----------------------------------------------------------------------------
`default_nettype none

package bq_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_FRAC_BITS = 27;
   localparam int STATE_BITS     = 48;

   localparam int COEF_BITS   = 32;
   localparam int NUM_COEFS   = 5;
   localparam int ADDR_BITS   = 5;
   localparam int INDEX_BITS  = 3;
   localparam int DATA_BITS   = 32;

   localparam int SAMPLE_FRAC = SAMPLE_BITS - 1;
   localparam int STATE_FRAC  = STATE_BITS - 8;
   localparam int PROD_FRAC   = SAMPLE_FRAC + COEF_FRAC_BITS;

   localparam int PROD_BITS   = COEF_BITS + 1 + SAMPLE_BITS;
   localparam int PROD_SHIFT  = PROD_FRAC - STATE_FRAC;
   localparam int TERM_BITS   = PROD_BITS - PROD_SHIFT;
   localparam int ACC_BITS    = ((TERM_BITS > STATE_BITS) ? TERM_BITS : STATE_BITS) + 2;
   localparam int Y_SHIFT     = STATE_FRAC - SAMPLE_FRAC;
   localparam int YW_BITS     = STATE_BITS - Y_SHIFT;

   localparam logic [INDEX_BITS-1:0] REG_B0 = INDEX_BITS'(0);
   localparam logic [INDEX_BITS-1:0] REG_B1 = INDEX_BITS'(1);
   localparam logic [INDEX_BITS-1:0] REG_B2 = INDEX_BITS'(2);
   localparam logic [INDEX_BITS-1:0] REG_A1 = INDEX_BITS'(3);
   localparam logic [INDEX_BITS-1:0] REG_A2 = INDEX_BITS'(4);

   localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

   localparam logic [STATE_BITS-1:0] STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
   localparam logic [STATE_BITS-1:0] STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef logic signed [COEF_BITS-1:0] coef_type;
   typedef coef_type [NUM_COEFS-1:0] coef_array_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_B0,
      ST_ACC_Y,
      ST_SAT_Y,
      ST_N1_D2,
      ST_N1_A1,
      ST_N1_DONE,
      ST_N2_DONE
   } state_type;

endpackage

`default_nettype wire

// File: design/bq_csr.sv
// ----------------------------------------------------------------------------
// Biquad coefficient registers
// APB-style register file holding the five Q5.27 filter coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module bq_csr
   import bq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [ADDR_BITS-1:0] csr_paddr,
   input  wire logic [DATA_BITS-1:0] csr_pwdata,
   output logic      [DATA_BITS-1:0] csr_prdata,
   output logic                      csr_pready,
   output coef_array_type            coefs
);

   coef_array_type          coef_ff;
   coef_array_type          coef_in;
   logic [INDEX_BITS-1:0]   index;
   logic                    index_ok;
   logic                    write_en;

   assign index      = csr_paddr[ADDR_BITS-1:2];
   assign index_ok   = index < INDEX_BITS'(NUM_COEFS);
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign coefs      = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (write_en && index_ok) begin
         coef_in[index] = csr_pwdata[COEF_BITS-1:0];
      end
      csr_prdata = index_ok ? DATA_BITS'(coef_ff[index]) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= {{((NUM_COEFS - 1) * COEF_BITS){1'b0}}, COEF_ONE};
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

`default_nettype wire

// File: design/biquad_iir_filter_df2t.sv
// Accepted samples pass MUL_B0, ACC_Y, SAT_Y, N1_D2, N1_A1, N1_DONE and N2_DONE,
// stalling until the output register is free; idle alone takes samples. The five
// products share one 33 x 24 multiplier and one accumulator under a sequencer.
// A finished result waits in an output register while the next sample starts.
// Reset zeroes both delay states, sets b0 to 1.0 and the other coefficients to 0.
// ----------------------------------------------------------------------------
// Biquad IIR filter, transposed direct form II
// Fixed-point second-order section with saturating 48-bit state words.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_iir_filter_df2t
   import bq_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  wire logic                          req_clear_state,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed      [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                               rsp_clipped,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic        [ADDR_BITS-1:0]   csr_paddr,
   input  wire logic        [DATA_BITS-1:0]   csr_pwdata,
   output logic             [DATA_BITS-1:0]   csr_prdata,
   output logic                               csr_pready
);

   coef_array_type coefs;

   state_type state_ff, state_in;

   logic signed [STATE_BITS-1:0]  delay_one_ff, delay_one_in;
   logic signed [STATE_BITS-1:0]  delay_two_ff, delay_two_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [SAMPLE_BITS-1:0] y_ff, y_in;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic                          clip_ff, clip_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out_ff, rsp_sample_out_in;
   logic                          rsp_clipped_ff, rsp_clipped_in;

   logic                          prod_en;
   logic signed [COEF_BITS:0]     mul_coef;
   logic signed [SAMPLE_BITS-1:0] mul_data;
   logic signed [TERM_BITS-1:0]   term;
   logic signed [ACC_BITS-1:0]    addend;
   logic signed [ACC_BITS-1:0]    sum;
   logic [ACC_BITS-STATE_BITS:0]  sum_top;
   logic                          sum_ovf;
   logic signed [STATE_BITS-1:0]  sum_sat;
   logic signed [YW_BITS-1:0]     y_wide;
   logic [YW_BITS-SAMPLE_BITS:0]  y_top;
   logic                          y_ovf;
   logic signed [SAMPLE_BITS-1:0] y_sat;
   logic                          out_free;

   bq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coefs       (coefs)
   );

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;
   assign rsp_clipped    = rsp_clipped_ff;
   assign out_free       = !rsp_valid_ff || rsp_ready;

   assign prod_in = mul_coef * mul_data;
   assign term    = prod_ff[PROD_BITS-1:PROD_SHIFT];
   assign sum     = ACC_BITS'(term) + addend;
   assign sum_top = sum[ACC_BITS-1:STATE_BITS-1];
   assign sum_ovf = !((&sum_top) || !(|sum_top));
   assign sum_sat = sum_ovf ? (sum[ACC_BITS-1] ? STATE_MIN : STATE_MAX)
                            : sum[STATE_BITS-1:0];

   assign y_wide = acc_ff[STATE_BITS-1:Y_SHIFT];
   assign y_top  = y_wide[YW_BITS-1:SAMPLE_BITS-1];
   assign y_ovf  = !((&y_top) || !(|y_top));
   assign y_sat  = y_ovf ? (y_wide[YW_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX)
                         : y_wide[SAMPLE_BITS-1:0];

   always_comb begin
      state_in          = state_ff;
      delay_one_in      = delay_one_ff;
      delay_two_in      = delay_two_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      x_in              = x_ff;
      y_in              = y_ff;
      acc_in            = acc_ff;
      clip_in           = clip_ff;
      rsp_sample_out_in = rsp_sample_out_ff;
      rsp_clipped_in    = rsp_clipped_ff;
      prod_en           = 1'b0;
      mul_coef          = '0;
      mul_data          = '0;
      addend            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = req_sample_in;
               clip_in  = 1'b0;
               state_in = ST_MUL_B0;
               if (req_clear_state) begin
                  delay_one_in = '0;
                  delay_two_in = '0;
               end
            end
         end
         ST_MUL_B0: begin
            prod_en  = 1'b1;
            mul_coef = {coefs[REG_B0][COEF_BITS-1], coefs[REG_B0]};
            mul_data = x_ff;
            state_in = ST_ACC_Y;
         end
         ST_ACC_Y: begin
            addend   = ACC_BITS'(delay_one_ff);
            acc_in   = ACC_BITS'(sum_sat);
            clip_in  = clip_ff || sum_ovf;
            state_in = ST_SAT_Y;
         end
         ST_SAT_Y: begin
            y_in     = y_sat;
            clip_in  = clip_ff || y_ovf;
            prod_en  = 1'b1;
            mul_coef = {coefs[REG_B1][COEF_BITS-1], coefs[REG_B1]};
            mul_data = x_ff;
            state_in = ST_N1_D2;
         end
         ST_N1_D2: begin
            addend   = ACC_BITS'(delay_two_ff);
            acc_in   = sum;
            prod_en  = 1'b1;
            mul_coef = -{coefs[REG_A1][COEF_BITS-1], coefs[REG_A1]};
            mul_data = y_ff;
            state_in = ST_N1_A1;
         end
         ST_N1_A1: begin
            addend       = acc_ff;
            delay_one_in = sum_sat;
            clip_in      = clip_ff || sum_ovf;
            prod_en      = 1'b1;
            mul_coef     = {coefs[REG_B2][COEF_BITS-1], coefs[REG_B2]};
            mul_data     = x_ff;
            state_in     = ST_N1_DONE;
         end
         ST_N1_DONE: begin
            acc_in   = sum;
            prod_en  = 1'b1;
            mul_coef = -{coefs[REG_A2][COEF_BITS-1], coefs[REG_A2]};
            mul_data = y_ff;
            state_in = ST_N2_DONE;
         end
         ST_N2_DONE: begin
            addend = acc_ff;
            if (out_free) begin
               delay_two_in      = sum_sat;
               rsp_valid_in      = 1'b1;
               rsp_sample_out_in = y_ff;
               rsp_clipped_in    = clip_ff || sum_ovf;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         delay_one_ff <= '0;
         delay_two_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         delay_one_ff <= delay_one_in;
         delay_two_ff <= delay_two_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff              <= x_in;
      y_ff              <= y_in;
      acc_ff            <= acc_in;
      clip_ff           <= clip_in;
      rsp_sample_out_ff <= rsp_sample_out_in;
      rsp_clipped_ff    <= rsp_clipped_in;
      if (prod_en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire
